// ===== src/dth_pkg.sv =====
// Shared types, codes and constants of the diff token hasher.
`timescale 1ns / 1ps
package dth_pkg;

	localparam int HASH_BITS_DEF   = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int HASH_MULT  = 293;
	localparam int HASH_MULT2 = HASH_MULT * HASH_MULT;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_HIGH  = 8'h80;

	// split modes
	localparam logic [2:0] MODE_LINE      = 3'd0;
	localparam logic [2:0] MODE_WORD      = 3'd1;
	localparam logic [2:0] MODE_CLASS     = 3'd2;
	localparam logic [2:0] MODE_EOL       = 3'd3;
	localparam logic [2:0] MODE_WS_AMOUNT = 3'd4;
	localparam logic [2:0] MODE_ALL_WS    = 3'd5;

	// character classes
	localparam logic [2:0] CLS_NONE  = 3'd0;
	localparam logic [2:0] CLS_CR    = 3'd1;
	localparam logic [2:0] CLS_WORD  = 3'd2;
	localparam logic [2:0] CLS_SPACE = 3'd3;
	localparam logic [2:0] CLS_OTHER = 3'd4;
	localparam logic [2:0] CLS_LF_IN = 3'd5;
	localparam logic [2:0] CLS_LF    = 3'd6;

	// configuration register indexes
	localparam logic [1:0] REG_SPLIT_MODE = 2'd0;
	localparam logic [1:0] REG_LINE_END   = 2'd1;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       end_of_file;
		logic       is_cr;
		logic       is_lf;
		logic       is_ws;
		logic       is_cspace;
		logic [2:0] cls;
	} dth_item_t;

endpackage

// ===== src/diff_token_hasher.sv =====
// Top level of the diff token hasher: config registers, front end, queue, back end.
// Path: an accepted byte is written into the queue, then popped by the back end, which
// registers its result in the output register.
// Throughput: one byte per cycle while the output is not stalled; a byte that yields two
// results holds the back end while the second result drains from its holding slot.
// Reset: arst_n asynchronous, active low; clears hash state, queue and config.
`timescale 1ns / 1ps
module diff_token_hasher #(
	parameter int HASH_BITS   = dth_pkg::HASH_BITS_DEF,
	parameter int QUEUE_DEPTH = dth_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [1:0]                          cfg_index,
	input  logic [7:0]                          cfg_data,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,   // byte_value
	input  logic                                s_axis_tlast,   // end_of_file
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [((HASH_BITS + 7) / 8) * 8-1:0] m_axis_tdata,  // token_hash
	output logic                                m_axis_tlast,   // file_done
	output logic [1:0]                          m_axis_tuser    // has_token, run_last
);
	import dth_pkg::*;

	localparam int TDATA_W = ((HASH_BITS + 7) / 8) * 8;

	logic [2:0]           split_mode_q;
	logic                 line_end_is_cr_q;
	logic                 q_full;
	logic                 q_push;
	dth_item_t            q_item;
	logic                 head_valid;
	dth_item_t            head_item;
	logic                 pop;
	logic [HASH_BITS-1:0] hash_out;
	logic                 has_token_out;
	logic                 run_last_out;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			split_mode_q     <= MODE_LINE;
			line_end_is_cr_q <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SPLIT_MODE: split_mode_q     <= cfg_data[2:0];
				REG_LINE_END:   line_end_is_cr_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	dth_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_item        (q_item)
	);

	dth_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	dth_back #(
		.HASH_BITS (HASH_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.split_mode     (split_mode_q),
		.line_end_is_cr (line_end_is_cr_q),
		.head_valid     (head_valid),
		.head_item      (head_item),
		.pop            (pop),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.hash_out       (hash_out),
		.has_token_out  (has_token_out),
		.file_done_out  (m_axis_tlast),
		.run_last_out   (run_last_out)
	);

	assign m_axis_tdata = TDATA_W'(hash_out);
	assign m_axis_tuser = {run_last_out, has_token_out};

endmodule

// ===== src/dth_front.sv =====
// Front end: accepts input bytes and classifies them for the queue.
`timescale 1ns / 1ps
module dth_front (
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [7:0]         s_axis_tdata,   // byte_value
	input  logic               s_axis_tlast,   // end_of_file
	input  logic               q_full,
	output logic               q_push,
	output dth_pkg::dth_item_t q_item
);
	import dth_pkg::*;

	logic [7:0] b;
	logic       alnum;

	assign b = s_axis_tdata;
	assign alnum = (b >= "0" && b <= "9") || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");

	always_comb begin
		q_item.byte_value  = b;
		q_item.end_of_file = s_axis_tlast;
		q_item.is_cr       = (b == CH_CR);
		q_item.is_lf       = (b == CH_LF);
		q_item.is_ws       = (b == CH_SPACE) || (b == CH_TAB);
		q_item.is_cspace   = (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
		if (b == CH_CR) begin
			q_item.cls = CLS_CR;
		end else if (b == CH_LF) begin
			q_item.cls = CLS_LF_IN;
		end else if (alnum || ((b & CH_HIGH) != 8'd0)) begin
			q_item.cls = CLS_WORD;
		end else if (q_item.is_cspace) begin
			q_item.cls = CLS_SPACE;
		end else begin
			q_item.cls = CLS_OTHER;
		end
	end

	assign s_axis_tready = !q_full;
	assign q_push = s_axis_tvalid && !q_full;

endmodule

// ===== src/dth_queue.sv =====
// Short queue of classified items between front and back end.
`timescale 1ns / 1ps
module dth_queue #(
	parameter int DEPTH = dth_pkg::QUEUE_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dth_pkg::dth_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output dth_pkg::dth_item_t head_item
);
	import dth_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dth_item_t     mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== src/dth_back.sv =====
// Back end: token state, hash update and result output with a second-result slot.
`timescale 1ns / 1ps
module dth_back #(
	parameter int HASH_BITS = dth_pkg::HASH_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            split_mode,
	input  logic                  line_end_is_cr,
	input  logic                  head_valid,
	input  dth_pkg::dth_item_t    head_item,
	output logic                  pop,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [HASH_BITS-1:0]  hash_out,
	output logic                  has_token_out,
	output logic                  file_done_out,
	output logic                  run_last_out
);
	import dth_pkg::*;

	typedef struct packed {
		logic [HASH_BITS-1:0] token_hash;
		logic                 has_token;
		logic                 file_done;
		logic                 run_last;
	} res_t;

	function automatic logic [HASH_BITS-1:0] mix1(input logic [HASH_BITS-1:0] h,
		input logic [7:0] c);
		return h * HASH_BITS'(HASH_MULT) + HASH_BITS'(c);
	endfunction

	// two updates folded: h*293^2 + a*293 + c
	function automatic logic [HASH_BITS-1:0] mix2(input logic [HASH_BITS-1:0] h,
		input logic [7:0] a, input logic [7:0] c);
		return h * HASH_BITS'(HASH_MULT2) + HASH_BITS'(a) * HASH_BITS'(HASH_MULT)
			+ HASH_BITS'(c);
	endfunction

	logic [HASH_BITS-1:0] h_q;
	logic [2:0]           pc_q;
	logic                 sw_q;
	logic                 sp_q;

	logic [HASH_BITS-1:0] hh;
	logic [2:0]           pc_t;
	logic [2:0]           cls_t;
	logic [2:0]           pc_n;
	logic                 sw_n;
	logic                 sp_n;
	logic                 sw_eff;
	logic                 sp_eff;
	logic                 nl;
	logic [1:0]           cnt;
	res_t                 r0;
	res_t                 r1;

	res_t                 out_q;
	res_t                 pend_q;
	logic                 out_v_q;
	logic                 pend_v_q;
	logic                 out_free;

	dth_item_t            it;
	logic                 eof;

	assign it  = head_item;
	assign eof = it.end_of_file;
	assign nl  = it.is_cr || it.is_lf;

	always_comb begin
		hh     = h_q;
		pc_t   = pc_q;
		cls_t  = it.cls;
		sw_eff = (split_mode == MODE_EOL || split_mode == MODE_WS_AMOUNT ||
			split_mode == MODE_ALL_WS) && sw_q;
		sp_eff = (split_mode == MODE_WS_AMOUNT) && sp_q;
		sw_n   = sw_eff;
		sp_n   = sp_eff;
		pc_n   = pc_q;
		cnt    = 2'd0;
		r0     = '0;
		r1     = '0;
		if (sw_eff && it.is_lf) begin
			sw_n = 1'b0;
			if (eof) begin
				r0.file_done = 1'b1;
				cnt = 2'd1;
			end
		end else begin
			if (sw_eff) begin
				sw_n = 1'b0;
			end
			case (split_mode)
				MODE_WORD: begin
					hh = mix1(hh, it.byte_value);
					if (eof || it.is_cspace) begin
						r0 = '{hh, 1'b1, eof, 1'b0};
						cnt = 2'd1;
						hh = '0;
					end
				end
				MODE_CLASS: begin
					if (cls_t != pc_t) begin
						if (cls_t == CLS_LF_IN) begin
							cls_t = CLS_LF;
							if (pc_t == CLS_CR) begin
								pc_t = CLS_NONE;
							end
						end
						if (pc_t != CLS_NONE) begin
							r0 = '{hh, 1'b1, 1'b0, 1'b0};
							cnt = 2'd1;
							hh = '0;
						end
						pc_n = cls_t;
					end
					hh = mix1(hh, it.byte_value);
					if (eof) begin
						if (cnt == 2'd0) begin
							r0 = '{hh, 1'b1, 1'b1, 1'b0};
						end else begin
							r1 = '{hh, 1'b1, 1'b1, 1'b0};
						end
						cnt = cnt + 2'd1;
					end
				end
				MODE_EOL: begin
					if (nl) begin
						if (it.is_cr && !eof) begin
							sw_n = 1'b1;
						end
						hh = mix1(hh, CH_LF);
						r0 = '{hh, 1'b1, eof, 1'b0};
						cnt = 2'd1;
						hh = '0;
					end else if (eof) begin
						hh = mix2(hh, it.byte_value, CH_LF);
						r0 = '{hh, 1'b1, 1'b1, 1'b0};
						cnt = 2'd1;
						hh = '0;
					end else begin
						hh = mix1(hh, it.byte_value);
					end
				end
				MODE_WS_AMOUNT, MODE_ALL_WS: begin
					if (it.is_ws) begin
						if (split_mode == MODE_WS_AMOUNT) begin
							sp_n = 1'b1;
						end
						if (eof) begin
							r0 = '{hh, 1'b1, 1'b1, 1'b0};
							cnt = 2'd1;
						end
					end else begin
						sp_n = 1'b0;
						if (it.is_cr && !eof) begin
							sw_n = 1'b1;
						end
						if (!nl) begin
							hh = sp_eff ? mix2(hh, CH_SPACE, it.byte_value)
								: mix1(hh, it.byte_value);
						end
						if (eof || nl) begin
							r0 = '{hh, 1'b1, eof, 1'b0};
							cnt = 2'd1;
							hh = '0;
						end
					end
				end
				default: begin
					hh = mix1(hh, it.byte_value);
					if (eof || (line_end_is_cr ? it.is_cr : it.is_lf)) begin
						r0 = '{hh, 1'b1, eof, 1'b0};
						cnt = 2'd1;
						hh = '0;
					end
				end
			endcase
		end
		r0.run_last = (cnt == 2'd1);
		r1.run_last = 1'b1;
		if (eof) begin
			hh   = '0;
			pc_n = CLS_NONE;
			sw_n = 1'b0;
			sp_n = 1'b0;
		end
	end

	assign out_free = !out_v_q || m_axis_tready;
	assign pop      = head_valid && out_free && !pend_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q      <= '0;
			pc_q     <= CLS_NONE;
			sw_q     <= 1'b0;
			sp_q     <= 1'b0;
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (pop) begin
				h_q  <= hh;
				pc_q <= pc_n;
				sw_q <= sw_n;
				sp_q <= sp_n;
			end
			if (pend_v_q && out_free) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (pop) begin
				out_v_q  <= (cnt != 2'd0);
				pend_v_q <= (cnt == 2'd2);
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pend_v_q && out_free) begin
			out_q <= pend_q;
		end else if (pop) begin
			out_q  <= r0;
			pend_q <= r1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign hash_out      = out_q.token_hash;
	assign has_token_out = out_q.has_token;
	assign file_done_out = out_q.file_done;
	assign run_last_out  = out_q.run_last;

endmodule

// ===== sim/testbench.sv =====
// Testbench for the diff token hasher: streams directed and random files and checks every token hash.
`timescale 1ns / 1ps
module testbench;
	import dth_pkg::*;

	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam int         MAX_REPORTS   = 10;
	localparam int         HOLD_CYCLES   = 400;
	localparam int         SETTLE_CYCLES = 8;

	typedef struct packed {
		logic [7:0] value;
		logic       eof;
	} file_byte_t;

	typedef struct packed {
		logic [31:0] hash;
		logic        has_token;
		logic        file_done;
		logic        run_last;
	} token_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index     = '0;
	logic [7:0]  cfg_data      = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = '0;
	logic        s_axis_tlast  = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic [1:0]  m_axis_tuser;

	file_byte_t file_bytes[$];
	token_t     tokens_due[$];
	token_t     step_tokens[$];

	// tokenizer state and register copies
	logic [31:0] acc_hash;
	logic [2:0]  last_cls;
	logic        lf_skip;
	logic        in_blank_run;
	logic [2:0]  mode_reg;
	logic        cr_ends_line;

	bit send_idle = 1'b1;
	bit recv_idle = 1'b1;
	bit hold_arm  = 1'b0;
	bit hold_done = 1'b0;
	int hold_left = 0;
	int send_gap  = 0;
	int recv_gap  = 0;
	int mismatch_cnt = 0;

	diff_token_hasher dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [31:0] mix(input logic [31:0] h, input logic [7:0] c);
		return h * 32'(HASH_MULT) + 32'(c);
	endfunction

	function automatic bit is_nl(input logic [7:0] c);
		return c == CH_CR || c == CH_LF;
	endfunction

	function automatic bit is_blank(input logic [7:0] c);
		return c == CH_SPACE || c == CH_TAB;
	endfunction

	function automatic bit is_cspace(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic bit is_alnum(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic emit_token(input logic [31:0] h, input logic has, input logic done);
		step_tokens.push_back('{h, has, done, 1'b0});
	endtask

	// CR or LF closes the line without being hashed (ws amount / all ws modes)
	task automatic close_plain(input logic [7:0] b, input logic eof);
		if (b == CH_CR && !eof)
			lf_skip = 1'b1;
		if (!is_nl(b))
			acc_hash = mix(acc_hash, b);
		if (eof || is_nl(b)) begin
			emit_token(acc_hash, 1'b1, eof);
			acc_hash = '0;
		end
	endtask

	task automatic tokenize_byte(input logic [7:0] b, input logic eof);
		logic [7:0] c;
		logic [2:0] cls;
		bit         swallowed;
		swallowed = 1'b0;
		if (mode_reg <= MODE_CLASS || mode_reg > MODE_ALL_WS) begin
			lf_skip      = 1'b0;
			in_blank_run = 1'b0;
		end else if (mode_reg != MODE_WS_AMOUNT) begin
			in_blank_run = 1'b0;
		end
		if (mode_reg >= MODE_EOL && mode_reg <= MODE_ALL_WS && lf_skip) begin
			lf_skip = 1'b0;
			if (b == CH_LF) begin
				swallowed = 1'b1;
				if (eof)
					emit_token('0, 1'b0, 1'b1);
			end
		end
		if (!swallowed) begin
			case (mode_reg)
				MODE_WORD: begin
					acc_hash = mix(acc_hash, b);
					if (eof || is_cspace(b)) begin
						emit_token(acc_hash, 1'b1, eof);
						acc_hash = '0;
					end
				end
				MODE_CLASS: begin
					if (b == CH_CR)
						cls = CLS_CR;
					else if (b == CH_LF)
						cls = CLS_LF_IN;
					else if (is_alnum(b) || b[7])
						cls = CLS_WORD;
					else if (is_cspace(b))
						cls = CLS_SPACE;
					else
						cls = CLS_OTHER;
					if (cls != last_cls) begin
						// LF after CR joins the CR token; any other LF stands alone
						if (cls == CLS_LF_IN) begin
							cls = CLS_LF;
							if (last_cls == CLS_CR)
								last_cls = CLS_NONE;
						end
						if (last_cls != CLS_NONE) begin
							emit_token(acc_hash, 1'b1, 1'b0);
							acc_hash = '0;
						end
						last_cls = cls;
					end
					acc_hash = mix(acc_hash, b);
					if (eof)
						emit_token(acc_hash, 1'b1, 1'b1);
				end
				MODE_EOL: begin
					c = b;
					if (is_nl(b)) begin
						if (b == CH_CR && !eof)
							lf_skip = 1'b1;
						c = CH_LF;
					end
					acc_hash = mix(acc_hash, c);
					if (eof && c != CH_LF)
						acc_hash = mix(acc_hash, CH_LF);
					if (eof || c == CH_LF) begin
						emit_token(acc_hash, 1'b1, eof);
						acc_hash = '0;
					end
				end
				MODE_WS_AMOUNT: begin
					if (in_blank_run) begin
						if (is_blank(b)) begin
							if (eof)
								emit_token(acc_hash, 1'b1, 1'b1);
						end else begin
							in_blank_run = 1'b0;
							if (!is_nl(b))
								acc_hash = mix(acc_hash, CH_SPACE);
							close_plain(b, eof);
						end
					end else if (is_blank(b)) begin
						in_blank_run = 1'b1;
						if (eof)
							emit_token(acc_hash, 1'b1, 1'b1);
					end else begin
						close_plain(b, eof);
					end
				end
				MODE_ALL_WS: begin
					if (is_blank(b)) begin
						if (eof)
							emit_token(acc_hash, 1'b1, 1'b1);
					end else begin
						close_plain(b, eof);
					end
				end
				default: begin
					acc_hash = mix(acc_hash, b);
					if (eof || b == (cr_ends_line ? CH_CR : CH_LF)) begin
						emit_token(acc_hash, 1'b1, eof);
						acc_hash = '0;
					end
				end
			endcase
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].run_last = 1'b1;
		foreach (step_tokens[i])
			tokens_due.push_back(step_tokens[i]);
		step_tokens.delete();
		if (eof) begin
			acc_hash     = '0;
			last_cls     = CLS_NONE;
			lf_skip      = 1'b0;
			in_blank_run = 1'b0;
		end
	endtask

	// input stream driver
	always @(posedge clk or negedge arst_n) begin : byte_driver
		file_byte_t nxt;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tlast  <= 1'b0;
			send_gap      <= 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				tokenize_byte(s_axis_tdata, s_axis_tlast);
			if (!s_axis_tvalid || s_axis_tready) begin
				if (send_gap > 0) begin
					send_gap      <= send_gap - 1;
					s_axis_tvalid <= 1'b0;
				end else if (file_bytes.size() > 0) begin
					nxt = file_bytes.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= nxt.value;
					s_axis_tlast  <= nxt.eof;
					send_gap      <= send_idle ? gap_len() : 0;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold-off so the block fills and stalls its input
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_arm && !hold_done) begin
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// output monitor
	always @(posedge clk or negedge arst_n) begin : token_monitor
		token_t got;
		token_t want;
		int     g;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap      <= 0;
		end else begin
			g = recv_gap;
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
				if (tokens_due.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS)
						$display("%0t: unexpected transaction hash %h has %b done %b last %b",
							$realtime, got.hash, got.has_token, got.file_done, got.run_last);
				end else begin
					want = tokens_due.pop_front();
					if (got.hash !== want.hash || got.has_token !== want.has_token ||
					    got.file_done !== want.file_done || got.run_last !== want.run_last) begin
						mismatch_cnt++;
						if (mismatch_cnt <= MAX_REPORTS)
							$display("%0t: mismatch exp hash %h has %b done %b last %b, got hash %h has %b done %b last %b",
								$realtime, want.hash, want.has_token, want.file_done, want.run_last,
								got.hash, got.has_token, got.file_done, got.run_last);
					end
				end
				g = recv_idle ? gap_len() : 0;
			end
			if (g > 0) begin
				recv_gap      <= g - 1;
				m_axis_tready <= 1'b0;
			end else begin
				recv_gap      <= 0;
				m_axis_tready <= (hold_left == 0);
			end
		end
	end

	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_SPLIT_MODE)
			mode_reg = val[2:0];
		else
			cr_ends_line = val[0];
	endtask

	task automatic configure(input logic [2:0] mode, input logic cr_end, input bit noisy);
		write_reg(REG_SPLIT_MODE, {noisy ? 5'($urandom_range(0, 31)) : 5'd0, mode});
		write_reg(REG_LINE_END, {noisy ? 7'($urandom_range(0, 127)) : 7'd0, cr_end});
		@(negedge clk);
	endtask

	task automatic push_byte(input logic [7:0] b, input logic eof);
		file_bytes.push_back('{b, eof});
	endtask

	task automatic push_text(input string s, input bit eof_at_end);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i], eof_at_end && i == s.len() - 1);
	endtask

	task automatic drain();
		@(negedge clk);
		while (file_bytes.size() != 0 || s_axis_tvalid || tokens_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] rand_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20)
			return 8'($urandom_range(0, 255));
		else if (r < 32)
			return CH_SPACE;
		else if (r < 40)
			return CH_TAB;
		else if (r < 47)
			return CH_CR;
		else if (r < 54)
			return CH_LF;
		else if (r < 58)
			return 8'($urandom_range(11, 12));
		else if (r < 74)
			return 8'("a" + $urandom_range(0, 25));
		else if (r < 81)
			return 8'("0" + $urandom_range(0, 9));
		else if (r < 89)
			return 8'("A" + $urandom_range(0, 25));
		return 8'($urandom_range(33, 47));
	endfunction

	// whole files with random content; sometimes the last one is cut short
	task automatic push_files(input int n);
		int sent;
		int len;
		int i;
		bit cut;
		sent = 0;
		cut  = ($urandom_range(0, 3) == 0);
		while (sent < n) begin
			len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 30);
			i = 0;
			while (i < len) begin
				if (i + 1 < len && $urandom_range(0, 9) == 0) begin
					push_byte(CH_CR, 1'b0);
					push_byte(CH_LF, i + 2 == len);
					i += 2;
					sent += 2;
				end else begin
					push_byte(rand_char(), i + 1 == len);
					i++;
					sent++;
				end
				if (cut && sent >= n)
					return;
			end
		end
	endtask

	initial begin
		logic [2:0] mode;
		acc_hash     = '0;
		last_cls     = CLS_NONE;
		lf_skip      = 1'b0;
		in_blank_run = 1'b0;
		mode_reg     = MODE_LINE;
		cr_ends_line = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		configure(MODE_LINE, 1'b0, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_text("\nx", 1'b1);
		drain();
		configure(MODE_LINE, 1'b1, 1'b0);
		push_text("\015\n", 1'b1);
		drain();
		configure(MODE_WORD, 1'b0, 1'b0);
		push_text("a\t\v", 1'b1);
		drain();
		configure(MODE_CLASS, 1'b0, 1'b0);
		push_text("\015\n\na ", 1'b1);
		drain();
		configure(MODE_EOL, 1'b0, 1'b0);
		push_text("\015\nz", 1'b1);
		push_text("\015\n", 1'b1);
		drain();
		configure(MODE_WS_AMOUNT, 1'b0, 1'b0);
		push_text("a \t\015\n", 1'b1);
		push_text(" ", 1'b1);
		drain();
		configure(MODE_ALL_WS, 1'b0, 1'b0);
		push_text("\tb ", 1'b1);
		drain();
		configure(MODE_SPARE_HI, 1'b1, 1'b0);
		push_text("q\n", 1'b1);
		drain();

		for (int p = 0; p < 12; p++) begin
			mode = (p < 8) ? 3'(p) : 3'($urandom_range(0, 7));
			configure(mode, 1'($urandom_range(0, 1)), 1'b1);
			send_idle = (p % 4 != 1);
			recv_idle = (p % 4 != 2);
			if (p == 3)
				hold_arm = 1'b1;
			push_files(85);
			drain();
		end

		if (mismatch_cnt == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== filelist.f =====
src/dth_pkg.sv
src/dth_front.sv
src/dth_queue.sv
src/dth_back.sv
src/diff_token_hasher.sv
sim/testbench.sv
